// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the bank mapper checker
// depends on nothing; macros take label, clock and property, ASSERT_CLK a reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/fcbm_pkg.sv =====
// types and constants of the flash cartridge bank mapper
// used by the save ram, the top level and the checker
package fcbm_pkg;

   localparam int SAVE_RAM_DEPTH   = 32768;
   localparam int SAVE_INDEX_BITS  = $clog2(SAVE_RAM_DEPTH);
   localparam int ROM_ADDRESS_BITS = 21;
   localparam int BANK_OFFSET_BITS = 14;

   // port A output register window and its pins
   localparam logic [4:0] PORT_A_REGION = 5'b00101;
   localparam logic [3:0] PORT_A_NIBBLE = 4'h1;
   localparam int PIN_CLOCK  = 0;
   localparam int PIN_DATA   = 1;
   localparam int PIN_SELECT = 2;
   localparam int BANK_ROM_BIT  = 7;
   localparam int BANK_HALF_BIT = 6;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_ROM  = 2'd1,
      SRC_RAM  = 2'd2
   } fcbm_source_type;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } fcbm_cmd_type;

   typedef struct packed {
      logic                       en;
      logic                       we;
      logic [SAVE_INDEX_BITS-1:0] addr;
      logic [7:0]                 wdata;
   } fcbm_ram_req_type;

endpackage

// ===== hw/rtl/flash_cart_bank_mapper_unit.sv =====
// top level of the flash cartridge bank mapper
// depends on fcbm_pkg and fcbm_save_ram
//
// Takes one CPU bus request per cycle while req_ready is high and answers each
// with one response; it passes the synchronous read of the 32 KB save ram and
// the s1 registers, then the output register. While a response waits on
// rsp_ready one more request is taken, then req_ready drops; rsp_ready reaches
// req_ready combinationally, so a full pipe still moves one request per cycle.
// The bank, shift and port A registers sit in flops and are updated as the
// request is taken. Save ram contents are undefined after reset; there is no
// clearing pass. The user must write the battery_fitted register on the csr port
// only while the block is idle; the block itself does not enforce it.
module flash_cart_bank_mapper_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  fcbm_pkg::fcbm_cmd_type                    req_cmd,
   input  logic [15:0]                               req_bus_address,
   input  logic [7:0]                                req_write_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output fcbm_pkg::fcbm_source_type                 rsp_source,
   output logic [fcbm_pkg::ROM_ADDRESS_BITS-1:0]     rsp_rom_address,
   output logic [7:0]                                rsp_read_data,
   output logic                                      rsp_save_request,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic                                      csr_battery_fitted
);
   import fcbm_pkg::*;

   logic battery_fitted_ff;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] bank_ff, bank_in;
   logic [7:0] last_port_a_ff, last_port_a_in;

   logic s1_valid_ff, s1_valid_in;
   fcbm_source_type s1_source_ff, s1_source_in;
   logic [ROM_ADDRESS_BITS-1:0] s1_rom_address_ff, s1_rom_address_in;
   logic s1_save_request_ff, s1_save_request_in;

   logic out_valid_ff, out_valid_in;
   fcbm_source_type out_source_ff;
   logic [ROM_ADDRESS_BITS-1:0] out_rom_address_ff;
   logic [7:0] out_read_data_ff, out_read_data_in;
   logic out_save_request_ff;

   fcbm_ram_req_type ram_req;
   logic [7:0] ram_rdata;

   logic accept, s1_advance, ram_window, port_a_hit;
   logic [7:0] rising;

   fcbm_save_ram u_save_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   assign s1_advance = !out_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign ram_window = req_bus_address[15] && !req_bus_address[14] && !bank_ff[BANK_ROM_BIT];
   assign port_a_hit = req_bus_address[15:11] == PORT_A_REGION &&
                       req_bus_address[3:0] == PORT_A_NIBBLE;
   assign rising     = req_write_data & ~last_port_a_ff;

   always_comb begin
      ram_req.en    = accept && ram_window;
      ram_req.we    = req_cmd == CMD_WRITE;
      ram_req.addr  = {bank_ff[BANK_HALF_BIT], req_bus_address[BANK_OFFSET_BITS-1:0]};
      ram_req.wdata = req_write_data;
   end

   // bank register and first stage decode
   always_comb begin
      shift_in           = shift_ff;
      bank_in            = bank_ff;
      last_port_a_in     = last_port_a_ff;
      s1_source_in       = SRC_NONE;
      s1_rom_address_in  = '0;
      s1_save_request_in = 1'b0;
      if (req_cmd == CMD_WRITE) begin
         if (port_a_hit) begin
            last_port_a_in = req_write_data;
            if (rising[PIN_CLOCK]) begin
               shift_in = {shift_ff[6:0], last_port_a_ff[PIN_DATA]};
            end else if (rising[PIN_SELECT]) begin
               // compared before bit 7 is forced
               s1_save_request_in = bank_ff[BANK_ROM_BIT] ^ shift_ff[BANK_ROM_BIT];
               bank_in = shift_ff;
               if (!battery_fitted_ff) begin
                  bank_in[BANK_ROM_BIT] = 1'b1;
               end
            end
         end
      end else if (req_bus_address[15]) begin
         if (req_bus_address[14]) begin
            s1_source_in      = SRC_ROM;
            s1_rom_address_in = {{(ROM_ADDRESS_BITS-BANK_OFFSET_BITS){1'b1}},
                                 req_bus_address[BANK_OFFSET_BITS-1:0]};
         end else if (!bank_ff[BANK_ROM_BIT]) begin
            s1_source_in = SRC_RAM;
         end else begin
            s1_source_in      = SRC_ROM;
            s1_rom_address_in = {bank_ff[6:0], req_bus_address[BANK_OFFSET_BITS-1:0]};
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_advance) begin
         out_valid_in = s1_valid_ff;
      end
      out_read_data_in = (s1_source_ff == SRC_RAM) ? ram_rdata : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         battery_fitted_ff <= 1'b0;
         shift_ff          <= '0;
         bank_ff           <= '0;
         last_port_a_ff    <= '0;
         s1_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            battery_fitted_ff <= csr_battery_fitted;
         end
         if (accept) begin
            shift_ff       <= shift_in;
            bank_ff        <= bank_in;
            last_port_a_ff <= last_port_a_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_source_ff       <= s1_source_in;
         s1_rom_address_ff  <= s1_rom_address_in;
         s1_save_request_ff <= s1_save_request_in;
      end
      if (s1_advance && s1_valid_ff) begin
         out_source_ff       <= s1_source_ff;
         out_rom_address_ff  <= s1_rom_address_ff;
         out_read_data_ff    <= out_read_data_in;
         out_save_request_ff <= s1_save_request_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_source       = out_source_ff;
   assign rsp_rom_address  = out_rom_address_ff;
   assign rsp_read_data    = out_read_data_ff;
   assign rsp_save_request = out_save_request_ff;

endmodule

// ===== hw/rtl/fcbm_save_ram.sv =====
// save ram: single port synchronous memory with a registered read
// depends on fcbm_pkg for the depth and the access struct
module fcbm_save_ram (
   input  logic                        clock,
   input  fcbm_pkg::fcbm_ram_req_type  ram_req,
   output logic [7:0]                  ram_rdata
);
   import fcbm_pkg::*;

   logic [7:0] mem [SAVE_RAM_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.en && ram_req.we) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (ram_req.en && !ram_req.we) begin
         rdata_ff <= mem[ram_req.addr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

// ===== hw/rtl/fcbm_checker.sv =====
// port level checks of the bank mapper response channel, and their bind
// depends on fcbm_pkg and assert_macros.svh
`include "assert_macros.svh"

module fcbm_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  fcbm_pkg::fcbm_source_type             rsp_source,
   input  logic [fcbm_pkg::ROM_ADDRESS_BITS-1:0] rsp_rom_address,
   input  logic [7:0]                            rsp_read_data,
   input  logic                                  rsp_save_request
);
   import fcbm_pkg::*;

   // a stalled response holds
   `ASSERT_CLK(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_source) && $stable(rsp_rom_address) && $stable(rsp_read_data) && $stable(rsp_save_request))
   `ASSERT_CLK(rom_addr_zero_a, clock, reset, rsp_valid && rsp_source != SRC_ROM |-> rsp_rom_address == '0)
   `ASSERT_CLK(rdata_zero_a, clock, reset, rsp_valid && rsp_source != SRC_RAM |-> rsp_read_data == 8'd0)
   // a save request only comes on a response with no source, as from a port A write
   `ASSERT_CLK(save_req_write_a, clock, reset, rsp_valid && rsp_save_request |-> rsp_source == SRC_NONE)

endmodule

bind flash_cart_bank_mapper_unit fcbm_checker u_fcbm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_source       (rsp_source),
   .rsp_rom_address  (rsp_rom_address),
   .rsp_read_data    (rsp_read_data),
   .rsp_save_request (rsp_save_request)
);

// ===== test/fcbm_access_checker.sv =====
// checker for the flash cartridge bank mapper: watches the request, response
// and csr channels, predicts every response and compares it field by field
// depends on fcbm_pkg only
module fcbm_access_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  fcbm_pkg::fcbm_cmd_type                req_cmd,
   input  logic [15:0]                           req_bus_address,
   input  logic [7:0]                            req_write_data,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  fcbm_pkg::fcbm_source_type             rsp_source,
   input  logic [fcbm_pkg::ROM_ADDRESS_BITS-1:0] rsp_rom_address,
   input  logic [7:0]                            rsp_read_data,
   input  logic                                  rsp_save_request,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic                                  csr_battery_fitted,
   output int                                    error_count,
   output int                                    outstanding,
   output int                                    checked_count,
   output int                                    save_flag_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fcbm_pkg::*;

   typedef struct packed {
      fcbm_source_type             source;
      logic [ROM_ADDRESS_BITS-1:0] rom_address;
      logic [7:0]                  read_data;
      logic                        save_request;
   } bus_answer_type;

   // shadow of the mapper registers and the save ram
   logic [7:0] shift_reg;
   logic [7:0] bank_reg;
   logic [7:0] port_a_last;
   logic       battery_en;
   logic [7:0] save_mem [SAVE_RAM_DEPTH];

   bus_answer_type pending_answers [$];

   task automatic note_failure(string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", msg);
   endtask

   function automatic bus_answer_type decode_access(fcbm_cmd_type cmd, logic [15:0] addr,
                                                    logic [7:0] data);
      bus_answer_type ans;
      logic [7:0] rising;
      logic [SAVE_INDEX_BITS-1:0] idx;
      ans.source       = SRC_NONE;
      ans.rom_address  = '0;
      ans.read_data    = '0;
      ans.save_request = 1'b0;
      idx = {bank_reg[BANK_HALF_BIT], addr[BANK_OFFSET_BITS-1:0]};
      if (cmd == CMD_WRITE) begin
         if (addr[15]) begin
            if (!addr[14] && !bank_reg[BANK_ROM_BIT]) save_mem[idx] = data;
         end else if (addr[15:11] == PORT_A_REGION && addr[3:0] == PORT_A_NIBBLE) begin
            rising = data & ~port_a_last;
            // a clock edge wins over a select edge in the same write
            if (rising[PIN_CLOCK]) begin
               shift_reg = {shift_reg[6:0], port_a_last[PIN_DATA]};
            end else if (rising[PIN_SELECT]) begin
               ans.save_request = bank_reg[BANK_ROM_BIT] ^ shift_reg[BANK_ROM_BIT];
               bank_reg = shift_reg;
               if (!battery_en) bank_reg[BANK_ROM_BIT] = 1'b1;
            end
            port_a_last = data;
         end
      end else if (addr[15]) begin
         if (addr[14]) begin
            ans.source      = SRC_ROM;
            ans.rom_address = {{(ROM_ADDRESS_BITS-BANK_OFFSET_BITS){1'b1}},
                               addr[BANK_OFFSET_BITS-1:0]};
         end else if (!bank_reg[BANK_ROM_BIT]) begin
            ans.source    = SRC_RAM;
            ans.read_data = save_mem[idx];
         end else begin
            ans.source      = SRC_ROM;
            ans.rom_address = {bank_reg[6:0], addr[BANK_OFFSET_BITS-1:0]};
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      bus_answer_type want;
      if (reset) begin
         shift_reg   = '0;
         bank_reg    = '0;
         port_a_last = '0;
         battery_en  = 1'b0;
         pending_answers.delete();
      end else begin
         if (csr_valid && csr_ready) battery_en = csr_battery_fitted;
         if (req_valid && req_ready)
            pending_answers.insert(pending_answers.size(),
                                   decode_access(req_cmd, req_bus_address, req_write_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               note_failure("response with no request waiting");
            end else begin
               want = pending_answers.pop_front();
               if (rsp_source !== want.source)
                  note_failure($sformatf("response %0d source: expected %0d, got %0d",
                                         checked_count, want.source, rsp_source));
               if (rsp_rom_address !== want.rom_address)
                  note_failure($sformatf("response %0d rom_address: expected %h, got %h",
                                         checked_count, want.rom_address, rsp_rom_address));
               if (rsp_read_data !== want.read_data)
                  note_failure($sformatf("response %0d read_data: expected %h, got %h",
                                         checked_count, want.read_data, rsp_read_data));
               if (rsp_save_request !== want.save_request)
                  note_failure($sformatf("response %0d save_request: expected %b, got %b",
                                         checked_count, want.save_request, rsp_save_request));
               if (want.save_request) save_flag_count++;
               checked_count++;
            end
         end
      end
      outstanding <= pending_answers.size();
   end

endmodule

// ===== test/flash_cart_bank_mapper_unit_test.sv =====
// testbench top for flash_cart_bank_mapper_unit: drives bus requests, csr
// writes and response back-pressure; depends on fcbm_pkg, the mapper RTL
// and fcbm_access_checker, which does all prediction and comparison
module flash_cart_bank_mapper_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fcbm_pkg::*;

   localparam int CYCLE_LIMIT     = 400_000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int PHASE_REQUESTS  = 100;
   localparam int SETTLE_CYCLES   = 8;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   fcbm_cmd_type req_cmd = CMD_READ;
   logic [15:0]  req_bus_address = '0;
   logic [7:0]   req_write_data = '0;
   logic         rsp_ready = 1'b0;
   logic         csr_valid = 1'b0;
   logic         csr_battery_fitted = 1'b0;

   logic                        req_ready;
   logic                        rsp_valid;
   fcbm_source_type             rsp_source;
   logic [ROM_ADDRESS_BITS-1:0] rsp_rom_address;
   logic [7:0]                  rsp_read_data;
   logic                        rsp_save_request;
   logic                        csr_ready;

   int error_count;
   int outstanding;
   int checked_count;
   int save_flag_count;
   int cycle_count = 0;
   bit sender_idles = 1'b0;
   bit hold_rsp_request = 1'b0;

   flash_cart_bank_mapper_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_bus_address    (req_bus_address),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_source         (rsp_source),
      .rsp_rom_address    (rsp_rom_address),
      .rsp_read_data      (rsp_read_data),
      .rsp_save_request   (rsp_save_request),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_battery_fitted (csr_battery_fitted)
   );

   fcbm_access_checker u_access_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_bus_address    (req_bus_address),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_source         (rsp_source),
      .rsp_rom_address    (rsp_rom_address),
      .rsp_read_data      (rsp_read_data),
      .rsp_save_request   (rsp_save_request),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_battery_fitted (csr_battery_fitted),
      .error_count        (error_count),
      .outstanding        (outstanding),
      .checked_count      (checked_count),
      .save_flag_count    (save_flag_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // slowest legal run: at most 576 requests, each behind the longest sender gap and
   // the longest response stall, ends well inside the CYCLE_LIMIT bound
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("flash_cart_bank_mapper_unit verification failed");
         $finish;
      end
   end

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [15:0] port_a_addr(logic [3:0] nibble);
      logic [6:0] mid;
      mid = 7'($urandom_range(0, 127));
      return {PORT_A_REGION, mid, nibble};
   endfunction

   task automatic send_request(fcbm_cmd_type cmd, logic [15:0] addr, logic [7:0] data);
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_bus_address <= addr;
      req_write_data  <= data;
      do @(posedge clock); while (!req_ready);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_battery(logic fitted);
      csr_valid          <= 1'b1;
      csr_battery_fitted <= fitted;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // serial bank load: two port A writes per bit, msb first, then a select edge
   task automatic load_bank(logic [7:0] value);
      logic [7:0] pins;
      for (int i = 7; i >= 0; i--) begin
         pins = 8'($urandom_range(0, 255));
         pins[PIN_SELECT] = 1'b0;
         pins[PIN_DATA]   = value[i];
         pins[PIN_CLOCK]  = 1'b0;
         send_request(CMD_WRITE, port_a_addr(PORT_A_NIBBLE), pins);
         pins = 8'($urandom_range(0, 255));
         pins[PIN_SELECT] = 1'b0;
         pins[PIN_DATA]   = value[i];
         pins[PIN_CLOCK]  = 1'b1;
         send_request(CMD_WRITE, port_a_addr(PORT_A_NIBBLE), pins);
      end
      pins = 8'($urandom_range(0, 255));
      pins[PIN_SELECT] = 1'b1;
      pins[PIN_CLOCK]  = 1'b1;
      send_request(CMD_WRITE, port_a_addr(PORT_A_NIBBLE), pins);
   endtask

   task automatic run_random_phase(int count);
      int n;
      int pick;
      logic [15:0] addr;
      logic [7:0] data;
      logic [3:0] nibble;
      fcbm_cmd_type cmd;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 39) == 0) sender_idles = !sender_idles;
         pick = $urandom_range(0, 99);
         addr = 16'($urandom_range(0, 65535));
         data = 8'($urandom_range(0, 255));
         cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
         if (pick < 10) begin
            load_bank(data);
            n += 17;
         end else begin
            if (pick < 35) begin
               addr[15:14] = 2'b10;
               cmd = CMD_READ;
            end else if (pick < 50) begin
               addr[15:14] = 2'b10;
               cmd = CMD_WRITE;
            end else if (pick < 65) begin
               addr[15:14] = 2'b11;
            end else if (pick < 85) begin
               // any address, either direction
            end else if (pick < 93) begin
               addr = port_a_addr(PORT_A_NIBBLE);
               cmd  = CMD_WRITE;
            end else begin
               // near misses of the port A register
               nibble = 4'($urandom_range(2, 16));
               if ($urandom_range(0, 1))
                  addr = port_a_addr(nibble);
               else
                  addr[3:0] = PORT_A_NIBBLE;
            end
            // reads of the save ram window stay on the prefilled ends of a half
            if (cmd == CMD_READ && addr[15:14] == 2'b10) addr[12:4] = {9{addr[13]}};
            send_request(cmd, addr, data);
            n++;
         end
      end
   endtask

   initial begin : response_sink
      int stall_left;
      int hold_left;
      bit calm;
      stall_left = 0;
      hold_left  = 0;
      calm       = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 199) == 0) calm = !calm;
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            hold_left = RSP_HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_length();
         end
      end
   end

   initial begin : stimulus
      logic [7:0] fill_byte;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_battery(1'b1);

      // fill the lowest and highest 16 bytes of both save ram halves
      for (int half = 0; half < 2; half++) begin
         if (half == 1) load_bank(8'h40);
         for (int offset = 0; offset < 32; offset++) begin
            fill_byte = 8'($urandom_range(0, 255));
            send_request(CMD_WRITE, {2'b10, {10{offset[4]}}, offset[3:0]}, fill_byte);
         end
      end

      sender_idles = 1'b1;
      send_request(CMD_READ,  16'h0000, 8'h00);
      send_request(CMD_READ,  16'hC000, 8'hFF);
      send_request(CMD_READ,  16'hFFFF, 8'h00);
      send_request(CMD_READ,  16'h8000, 8'h00);
      send_request(CMD_WRITE, 16'hBFFF, 8'hFF);
      send_request(CMD_READ,  16'hBFFF, 8'h00);
      send_request(CMD_WRITE, 16'hC123, 8'h55);
      send_request(CMD_WRITE, port_a_addr(4'h2), 8'h07);
      send_request(CMD_WRITE, 16'h3001, 8'h07);
      send_request(CMD_WRITE, 16'h2FF1, 8'h00);
      // clock and select rise together: shift only
      send_request(CMD_WRITE, 16'h2801, 8'h05);
      // bit 7 set with battery fitted: rom banking plus a save request
      load_bank(8'hC5);
      send_request(CMD_READ,  16'h8000, 8'h00);
      send_request(CMD_WRITE, 16'h8123, 8'hA5);
      send_request(CMD_READ,  16'hBFFF, 8'h00);

      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         write_battery(phase[0]);
         if (phase == 1) hold_rsp_request = 1'b1;
         run_random_phase(PHASE_REQUESTS);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("checked %0d responses: save ram halves, rom and ram banking, port A",
               checked_count);
      $display("edge cases, battery fitted and absent, %0d save requests flagged",
               save_flag_count);
      if (error_count == 0 && outstanding == 0) begin
         $display("flash_cart_bank_mapper_unit verification clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("flash_cart_bank_mapper_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== flash_cart_bank_mapper_unit.f =====
+incdir+hw/rtl
hw/rtl/fcbm_pkg.sv
hw/rtl/fcbm_save_ram.sv
hw/rtl/flash_cart_bank_mapper_unit.sv
hw/rtl/fcbm_checker.sv
test/fcbm_access_checker.sv
test/flash_cart_bank_mapper_unit_test.sv
